>>> hw/rtl/nsec_type_bitmap_decoder_core_defines.svh
// Assertion helpers shared by the decoder modules.
`ifndef NSEC_TYPE_BITMAP_DECODER_CORE_DEFINES_SVH
`define NSEC_TYPE_BITMAP_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define NTBD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define NTBD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ntbd_pkg.sv
package ntbd_pkg;

   // Default depth of the queue between the front and the back part.
   localparam int unsigned NTBD_QUEUE_DEPTH = 4;

   // Longest bitmap of one window block, in bytes.
   localparam logic [7:0] NTBD_MAX_BITMAP_LEN = 8'd32;

   // Configuration register map.
   localparam int unsigned NTBD_CSR_ADDR_W = 2;
   localparam logic [NTBD_CSR_ADDR_W-1:0] NTBD_ADDR_MAX_RDATA = 2'd0;
   localparam logic [15:0] NTBD_MAX_RDATA_RESET = 16'hFFFF;

   // Parser phase within one window block.
   typedef enum logic [1:0] {
      PH_WINDOW = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BITMAP = 2'd2
   } phase_type;

   // Kind of one result.
   typedef enum logic [1:0] {
      KIND_TYPE = 2'd0,
      KIND_OK   = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   // One classified byte: the type bits to expand and an optional end result.
   typedef struct packed {
      logic [15:0] type_base;
      logic [7:0]  type_mask;
      logic        has_end;
      kind_type    end_kind;
   } ntbd_entry_type;

endpackage

>>> hw/rtl/nsec_type_bitmap_decoder_core.sv
// Type bit maps decoder for NSEC record data.
// The req channel takes one byte of record data per transfer in req_tdata,
// with req_tlast on the final byte of the record. The rsp channel returns
// results: rsp_tdata carries the resource record type, rsp_tuser the kind
// (type present, record ended well, malformed) and rsp_tlast marks the last
// result caused by one request. Bytes that cause no result return nothing.
// The csr port holds max_rdata_bytes at address 0; a record longer than that
// ends malformed. Write it only while no record is in flight.
// A request is taken every cycle while the entry queue has room; the front
// parser classifies it in the accepting cycle and queues at most one entry.
// The back part expands an entry at one result per cycle while the receiver
// takes them, so a bitmap byte with k set bits yields k results, plus one
// for an end result. Entries reach the output via the work register.
// When the receiver stalls, the output register holds its result, the back
// part waits and the queue fills; req_tready drops once the queue is full.
// Reset clears the parser, the queue and the output register and sets
// max_rdata_bytes to 65535.
module nsec_type_bitmap_decoder_core
   import ntbd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = NTBD_QUEUE_DEPTH
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // rdata_byte[7:0]
   input  logic                       req_tlast,   // final_byte
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // rr_type[15:0]
   output logic [1:0]                 rsp_tuser,   // kind[1:0]
   output logic                       rsp_tlast,   // last_of_run
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [NTBD_CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [15:0]    max_rdata_ff, max_rdata_in;
   logic           q_full;
   logic           q_push;
   logic           q_pop;
   logic           q_not_empty;
   ntbd_entry_type q_push_entry;
   ntbd_entry_type q_head;

   // Configuration register.
   assign csr_pready = 1'b1;

   always_comb begin
      max_rdata_in = max_rdata_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr == NTBD_ADDR_MAX_RDATA) begin
         max_rdata_in = csr_pwdata[15:0];
      end
      csr_prdata = (csr_paddr == NTBD_ADDR_MAX_RDATA) ? {16'd0, max_rdata_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rdata_ff <= NTBD_MAX_RDATA_RESET;
      end else begin
         max_rdata_ff <= max_rdata_in;
      end
   end

   // Front parser.
   ntbd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .max_rdata_bytes (max_rdata_ff),
      .queue_full      (q_full),
      .push            (q_push),
      .push_entry      (q_push_entry)
   );

   // Entry queue between front and back.
   ntbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // Back expander and output register.
   ntbd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (q_not_empty),
      .queue_head      (q_head),
      .pop             (q_pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast)
   );

endmodule

>>> hw/rtl/ntbd_front.sv
module ntbd_front
   import ntbd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,   // rdata_byte[7:0]
   input  logic           req_tlast,   // final_byte
   input  logic [15:0]    max_rdata_bytes,
   input  logic           queue_full,
   output logic           push,
   output ntbd_entry_type push_entry
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  window_ff, window_in;
   logic [5:0]  left_ff, left_in;
   logic [4:0]  index_ff, index_in;
   logic [15:0] count_ff, count_in;
   logic        dropping_ff, dropping_in;

   logic        accept;
   logic [16:0] count_sum;
   logic [5:0]  left_dec;

   // A byte is taken whenever the queue has room for its entry.
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign count_sum  = {1'b0, count_ff} + 17'd1;
   assign left_dec   = left_ff - 6'd1;

   // Record parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WINDOW;
         window_ff   <= '0;
         left_ff     <= '0;
         index_ff    <= '0;
         count_ff    <= '0;
         dropping_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         window_ff   <= window_in;
         left_ff     <= left_in;
         index_ff    <= index_in;
         count_ff    <= count_in;
         dropping_ff <= dropping_in;
      end
   end

   // Classify the byte and build its queue entry.
   always_comb begin
      phase_in    = phase_ff;
      window_in   = window_ff;
      left_in     = left_ff;
      index_in    = index_ff;
      count_in    = count_ff;
      dropping_in = dropping_ff;
      push        = 1'b0;
      push_entry  = '{type_base: 16'd0, type_mask: 8'd0, has_end: 1'b0,
                      end_kind: KIND_TYPE};

      if (accept) begin
         if (dropping_ff) begin
            // After an error, bytes are dropped silently up to the final one.
            if (req_tlast) begin
               dropping_in = 1'b0;
            end
         end else if (count_sum > {1'b0, max_rdata_bytes}) begin
            // Record grew beyond the configured limit.
            push                = 1'b1;
            push_entry.has_end  = 1'b1;
            push_entry.end_kind = KIND_BAD;
            phase_in            = PH_WINDOW;
            window_in           = '0;
            left_in             = '0;
            index_in            = '0;
            count_in            = '0;
            dropping_in         = !req_tlast;
         end else begin
            count_in = count_sum[15:0];
            case (phase_ff)
               PH_LENGTH: begin
                  if (req_tdata == 8'd0 || req_tdata > NTBD_MAX_BITMAP_LEN || req_tlast) begin
                     push                = 1'b1;
                     push_entry.has_end  = 1'b1;
                     push_entry.end_kind = KIND_BAD;
                     phase_in            = PH_WINDOW;
                     window_in           = '0;
                     left_in             = '0;
                     index_in            = '0;
                     count_in            = '0;
                     dropping_in         = !req_tlast;
                  end else begin
                     left_in  = req_tdata[5:0];
                     index_in = '0;
                     phase_in = PH_BITMAP;
                  end
               end
               PH_BITMAP: begin
                  push_entry.type_base = {window_ff, index_ff, 3'b000};
                  push_entry.type_mask = req_tdata;
                  push                 = (req_tdata != 8'd0) || req_tlast;
                  index_in             = index_ff + 5'd1;
                  left_in              = left_dec;
                  if (left_dec == 6'd0) begin
                     phase_in = PH_WINDOW;
                  end
                  if (req_tlast) begin
                     // A block still owed bytes means the record was cut short.
                     push_entry.has_end  = 1'b1;
                     push_entry.end_kind = (left_dec != 6'd0) ? KIND_BAD : KIND_OK;
                     phase_in            = PH_WINDOW;
                     window_in           = '0;
                     left_in             = '0;
                     index_in            = '0;
                     count_in            = '0;
                  end
               end
               default: begin
                  // Window byte; a lone final byte here ends the record well.
                  window_in = req_tdata;
                  phase_in  = PH_LENGTH;
                  if (req_tlast) begin
                     push                = 1'b1;
                     push_entry.has_end  = 1'b1;
                     push_entry.end_kind = KIND_OK;
                     phase_in            = PH_WINDOW;
                     window_in           = '0;
                     left_in             = '0;
                     index_in            = '0;
                     count_in            = '0;
                  end
               end
            endcase
         end
      end
   end

endmodule

>>> hw/rtl/ntbd_queue.sv
module ntbd_queue
   import ntbd_pkg::*;
#(
   parameter int unsigned DEPTH = NTBD_QUEUE_DEPTH
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  ntbd_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           not_empty,
   output ntbd_entry_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ntbd_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`include "nsec_type_bitmap_decoder_core_defines.svh"

   `NTBD_ASSERT_NOW(a_no_overflow, push, !full || pop, "queue written while full")
   `NTBD_ASSERT_NOW(a_no_underflow, pop, not_empty, "queue read while empty")
   `NTBD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= FULL_CNT, "queue count beyond depth")

endmodule

>>> hw/rtl/ntbd_back.sv
module ntbd_back
   import ntbd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           queue_not_empty,
   input  ntbd_entry_type queue_head,
   output logic           pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [15:0]    rsp_tdata,   // rr_type[15:0]
   output logic [1:0]     rsp_tuser,   // kind[1:0]
   output logic           rsp_tlast    // last_of_run
);

   // Entry being expanded.
   logic        work_valid_ff, work_valid_in;
   logic [15:0] work_base_ff, work_base_in;
   logic [7:0]  work_mask_ff, work_mask_in;
   logic        work_end_ff, work_end_in;
   kind_type    work_kind_ff, work_kind_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_type_ff, out_type_in;
   kind_type    out_kind_ff, out_kind_in;
   logic        out_last_ff, out_last_in;

   logic        advance;
   logic        emit;
   logic        done;
   logic [2:0]  bit_sel;
   logic [7:0]  mask_left;

   assign advance = !out_valid_ff || rsp_tready;
   assign emit    = work_valid_ff && advance;

   // Highest set bit of the remaining mask; bit 7 is type offset 0.
   always_comb begin
      bit_sel = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (work_mask_ff[i]) begin
            bit_sel = 3'(7 - i);
         end
      end
      mask_left = work_mask_ff & ~(8'h80 >> bit_sel);
   end

   // One result per cycle unless stalled: types, then end result.
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_type_in   = out_type_ff;
      out_kind_in   = out_kind_ff;
      out_last_in   = out_last_ff;
      work_valid_in = work_valid_ff;
      work_base_in  = work_base_ff;
      work_mask_in  = work_mask_ff;
      work_end_in   = work_end_ff;
      work_kind_in  = work_kind_ff;
      done          = 1'b0;

      if (emit) begin
         out_valid_in = 1'b1;
         if (work_mask_ff != 8'd0) begin
            out_type_in  = work_base_ff | {13'd0, bit_sel};
            out_kind_in  = KIND_TYPE;
            done         = (mask_left == 8'd0) && !work_end_ff;
            out_last_in  = done;
            work_mask_in = mask_left;
         end else begin
            out_type_in = 16'd0;
            out_kind_in = work_kind_ff;
            out_last_in = 1'b1;
            done        = 1'b1;
         end
         if (done) begin
            work_valid_in = 1'b0;
         end
      end

      pop = queue_not_empty && (!work_valid_ff || done);
      if (pop) begin
         work_valid_in = 1'b1;
         work_base_in  = queue_head.type_base;
         work_mask_in  = queue_head.type_mask;
         work_end_in   = queue_head.has_end;
         work_kind_in  = queue_head.end_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_base_ff <= work_base_in;
      work_mask_ff <= work_mask_in;
      work_end_ff  <= work_end_in;
      work_kind_ff <= work_kind_in;
      out_type_ff  <= out_type_in;
      out_kind_ff  <= out_kind_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_type_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

`include "nsec_type_bitmap_decoder_core_defines.svh"

   `NTBD_ASSERT_NOW(a_work_not_empty, work_valid_ff,
      (work_mask_ff != 8'd0) || work_end_ff, "loaded entry has nothing to emit")
   `NTBD_ASSERT_NOW(a_end_is_last, out_valid_ff && (out_kind_ff != KIND_TYPE),
      out_last_ff, "end result not marked last")
   `NTBD_ASSERT_NEXT(a_done_clears, emit && done && !pop,
      !work_valid_ff, "finished entry still held")

endmodule

>>> tb/nsec_type_bitmap_decoder_core_tb.sv
`timescale 1ns / 100ps

module nsec_type_bitmap_decoder_core_tb;
   import ntbd_pkg::*;

   // One result of the decoder as seen on the rsp channel.
   typedef struct packed {
      logic [15:0] rr_type;
      kind_type    kind;
      logic        last;
   } nsec_result_type;

   // One directed request; a typed row carries its own expected end result.
   typedef struct packed {
      logic [7:0] data;
      logic       fin;
      logic       typed;
      logic [1:0] n_results;
      kind_type   kind;
   } directed_row_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int NUM_PHASES = 8;
   localparam int LONG_STALL_CYCLES = 80;
   localparam int DRAIN_CYCLES = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // rdata_byte[7:0]
   logic        req_tlast = 1'b0;    // final_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // rr_type[15:0]
   logic [1:0]  rsp_tuser;           // kind[1:0]
   logic        rsp_tlast;           // last_of_run
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [NTBD_CSR_ADDR_W-1:0] csr_paddr = NTBD_ADDR_MAX_RDATA;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   nsec_type_bitmap_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Decoder state mirrored by the testbench.
   logic [15:0] max_rdata_bytes;
   phase_type   dec_phase;
   logic [7:0]  dec_window;
   logic [5:0]  dec_left;
   logic [4:0]  dec_index;
   logic [15:0] dec_count;
   logic        dec_dropping;

   nsec_result_type byte_results[$];
   nsec_result_type due_results[$];
   logic [8:0]      record_bytes[$];   // {final, data}

   idle_mode_type idle_mode = IDLE_NONE;
   int            error_count = 0;
   int            sent_requests = 0;
   logic          long_stall_toggle = 1'b0;
   logic          long_stall_seen = 1'b0;
   int            long_stall_left = 0;

   function automatic void clear_record();
      dec_phase = PH_WINDOW;
      dec_window = 8'h00;
      dec_left = 6'd0;
      dec_index = 5'd0;
      dec_count = 16'd0;
      dec_dropping = 1'b0;
   endfunction

   function automatic void add_result(input logic [15:0] rr_type, input kind_type kind);
      nsec_result_type r;
      r.rr_type = rr_type;
      r.kind = kind;
      r.last = 1'b0;
      byte_results.insert(byte_results.size(), r);
   endfunction

   function automatic void close_run();
      if (byte_results.size() != 0) begin
         byte_results[byte_results.size() - 1].last = 1'b1;
      end
   endfunction

   // A malformed record ends at once; without the final byte the rest is dropped.
   function automatic void mark_malformed(input logic fin);
      add_result(16'h0000, KIND_BAD);
      clear_record();
      dec_dropping = !fin;
      close_run();
   endfunction

   // Decodes one byte of record data into byte_results.
   function automatic void nsec_decode_byte(input logic [7:0] b, input logic fin);
      logic [16:0] count;
      logic [15:0] base;
      byte_results.delete();
      if (dec_dropping) begin
         if (fin) begin
            clear_record();
         end
         return;
      end
      count = {1'b0, dec_count} + 17'd1;
      if (count > {1'b0, max_rdata_bytes}) begin
         mark_malformed(fin);
         return;
      end
      dec_count = count[15:0];
      case (dec_phase)
         PH_LENGTH: begin
            if (b == 8'd0 || b > NTBD_MAX_BITMAP_LEN || fin) begin
               mark_malformed(fin);
               return;
            end
            dec_left = b[5:0];
            dec_index = 5'd0;
            dec_phase = PH_BITMAP;
         end
         PH_BITMAP: begin
            base = {dec_window, dec_index, 3'b000};
            for (int i = 0; i < 8; i++) begin
               if (b[7 - i]) begin
                  add_result(base + 16'(i), KIND_TYPE);
               end
            end
            dec_index = dec_index + 5'd1;
            dec_left = dec_left - 6'd1;
            if (dec_left == 6'd0) begin
               dec_phase = PH_WINDOW;
            end
            if (fin) begin
               if (dec_left != 6'd0) begin
                  mark_malformed(1'b1);
                  return;
               end
               add_result(16'h0000, KIND_OK);
               clear_record();
            end
         end
         default: begin
            dec_window = b;
            dec_phase = PH_LENGTH;
            if (fin) begin
               add_result(16'h0000, KIND_OK);
               clear_record();
            end
         end
      endcase
      close_run();
   endfunction

   function automatic int idle_percent(input logic receiver_side);
      case (idle_mode)
         IDLE_SENDER:   return receiver_side ? 0 : 59;
         IDLE_RECEIVER: return receiver_side ? 59 : 0;
         IDLE_BOTH:     return 20;
         default:       return 0;
      endcase
   endfunction

   // Offers one request, waits for its acceptance and records what it should cause.
   task automatic send_request(input logic [7:0] data, input logic fin, input logic typed,
                               input logic [1:0] n_results, input kind_type kind);
      nsec_result_type r;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_percent(1'b0)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      nsec_decode_byte(data, fin);
      if (typed) begin
         if (n_results != 2'd0) begin
            r.rr_type = 16'h0000;
            r.kind = kind;
            r.last = 1'b1;
            due_results.insert(due_results.size(), r);
         end
      end else begin
         foreach (byte_results[i]) due_results.insert(due_results.size(), byte_results[i]);
      end
      sent_requests++;
   endtask

   // Lowers tvalid and waits until every expected result has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_rdata(input logic [15:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= NTBD_ADDR_MAX_RDATA;
      csr_pwdata <= {16'h0000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      max_rdata_bytes = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [7:0] bitmap_content();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 8'hFF;
      if (pick == 1) return 8'h00;
      return 8'($urandom);
   endfunction

   // Appends one window block: window number, length and bitmap bytes.
   function automatic void add_block();
      int len;
      len = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(1, 4);
      record_bytes.insert(record_bytes.size(), {1'b0, 8'($urandom)});
      record_bytes.insert(record_bytes.size(), {1'b0, 8'(len)});
      for (int i = 0; i < len; i++) begin
         record_bytes.insert(record_bytes.size(), {1'b0, bitmap_content()});
      end
   endfunction

   // Builds one record: mostly well formed, sometimes cut short, bad or noise.
   function automatic void build_record();
      int pick;
      int keep;
      logic [8:0] tail;
      record_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         for (int w = $urandom_range(1, 3); w > 0; w--) add_block();
         if (pick < 8) begin
            record_bytes.insert(record_bytes.size(), {1'b0, 8'($urandom)});
         end else if (pick >= 75) begin
            keep = $urandom_range(1, record_bytes.size() - 1);
            while (record_bytes.size() > keep) void'(record_bytes.pop_back());
         end
      end else if (pick < 93) begin
         record_bytes.insert(record_bytes.size(), {1'b0, 8'($urandom)});
         record_bytes.insert(record_bytes.size(),
                             {1'b0, ($urandom_range(0, 1) == 0) ? 8'd0
                                                                : 8'($urandom_range(33, 255))});
         for (int i = $urandom_range(0, 3); i > 0; i--) begin
            record_bytes.insert(record_bytes.size(), {1'b0, 8'($urandom)});
         end
      end else begin
         for (int i = $urandom_range(1, 6); i > 0; i--) begin
            record_bytes.insert(record_bytes.size(), {1'b0, 8'($urandom)});
         end
      end
      tail = record_bytes.pop_back();
      tail[8] = 1'b1;
      record_bytes.insert(record_bytes.size(), tail);
   endfunction

   // Receiver: random stalls, plus one long hold-off when requested.
   always @(negedge clock) begin
      if (long_stall_toggle != long_stall_seen) begin
         long_stall_seen <= long_stall_toggle;
         long_stall_left <= LONG_STALL_CYCLES;
         rsp_tready <= 1'b0;
      end else if (long_stall_left != 0) begin
         long_stall_left <= long_stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= idle_percent(1'b1));
      end
   end

   // Every accepted result must match the oldest expected one.
   always @(posedge clock) begin
      nsec_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            error_count++;
            $display("%0t: expected no result, got rr_type=%h kind=%0d last=%b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = due_results.pop_front();
            if (rsp_tdata !== want.rr_type || rsp_tuser !== want.kind ||
                rsp_tlast !== want.last) begin
               error_count++;
               $display({"%0t: expected rr_type=%h kind=%0d last=%b, ",
                         "got rr_type=%h kind=%0d last=%b"},
                        $time, want.rr_type, want.kind, want.last,
                        rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // Watchdog for a hung run.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // Directed records: good blocks, bad lengths, blocks cut short, leftover window bytes.
   directed_row_type directed_rows[23] = '{
      '{8'h00, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h01, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'hFF, 1'b0, 1'b0, 2'd0, KIND_TYPE},
      '{8'hFF, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h02, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h80, 1'b0, 1'b0, 2'd0, KIND_TYPE},
      '{8'h01, 1'b1, 1'b0, 2'd0, KIND_TYPE},
      '{8'h05, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h00, 1'b0, 1'b1, 2'd1, KIND_BAD},
      '{8'hAA, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h55, 1'b1, 1'b1, 2'd0, KIND_TYPE},
      '{8'h01, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h21, 1'b1, 1'b1, 2'd1, KIND_BAD},
      '{8'h02, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h03, 1'b1, 1'b1, 2'd1, KIND_BAD},
      '{8'h10, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h03, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h00, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h41, 1'b1, 1'b0, 2'd0, KIND_TYPE},
      '{8'h7F, 1'b1, 1'b1, 2'd1, KIND_OK},
      '{8'h00, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h01, 1'b0, 1'b1, 2'd0, KIND_TYPE},
      '{8'h00, 1'b1, 1'b1, 2'd1, KIND_OK}
   };

   logic [15:0] phase_limit[NUM_PHASES];
   int          phase_target[NUM_PHASES];

   initial begin
      logic [8:0] next_byte;
      max_rdata_bytes = NTBD_MAX_RDATA_RESET;
      clear_record();
      phase_limit = '{16'hFFFF, 16'd12, 16'd1, 16'd0, 16'hFFFF,
                      16'($urandom_range(2, 40)), 16'd5, 16'd300};
      phase_target = '{30, 25, 15, 15, 30, 25, 20, 30};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].typed,
                      directed_rows[i].n_results, directed_rows[i].kind);
      end

      // Random phases, each with its own size limit and idling pattern.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_max_rdata(phase_limit[p]);
         idle_mode = idle_mode_type'(p % 4);
         if (p == 4) begin
            long_stall_toggle = ~long_stall_toggle;
         end
         sent_requests = 0;
         while (sent_requests < phase_target[p]) begin
            build_record();
            while (record_bytes.size() != 0) begin
               next_byte = record_bytes.pop_front();
               send_request(next_byte[7:0], next_byte[8], 1'b0, 2'd0, KIND_TYPE);
            end
         end
      end

      drain();
      if (error_count == 0 && due_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
